[hw/rtl/vt4_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vt4_pkg;

    localparam int DATA_W        = 32;
    localparam int LANES         = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIM_DEF       = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    typedef logic signed [DATA_W-1:0] data_t;

    // stage load enables handed to every lane
    typedef struct packed {
        logic load_1;
        logic load_2;
        logic load_3;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/vt4_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module vt4_lane #(
    parameter int COLS      = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic              clk,
    input  wire vt4_pkg::pipe_ctrl_t ctrl,
    input  wire vt4_pkg::data_t    row [COLS],
    input  wire vt4_pkg::data_t    vec [COLS],
    output vt4_pkg::data_t         result,
    output logic                   clip
);

    import vt4_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int PAIRS  = (COLS + 1) / 2;
    localparam int SH_W   = SUM_W - FRAC_BITS;

    logic signed [PROD_W-1:0] prod_reg [COLS];
    logic signed [PAIR_W-1:0] pair_reg [PAIRS];
    logic signed [PAIR_W-1:0] pair_next [PAIRS];
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SH_W-1:0]   shifted;
    logic                     ovf;
    data_t                    result_reg;
    data_t                    result_next;
    logic                     clip_reg;

    // stage 1: one product per column
    always_ff @(posedge clk)
    begin
        if (ctrl.load_1)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                prod_reg[c] <= row[c] * vec[c];
            end
        end
    end

    // stage 2: pairwise sums, an odd column passes alone
    for (genvar k = 0; k < PAIRS; k++) begin : g_pair
        if (2 * k + 1 < COLS) begin : g_two
            assign pair_next[k] = PAIR_W'(prod_reg[2*k]) + PAIR_W'(prod_reg[2*k+1]);
        end else begin : g_one
            assign pair_next[k] = PAIR_W'(prod_reg[2*k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_2)
        begin
            for (int k = 0; k < PAIRS; k++)
            begin
                pair_reg[k] <= pair_next[k];
            end
        end
    end

    // stage 3: final sum, floor shift, saturate
    if (PAIRS > 1) begin : g_sum2
        assign sum_next = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
    end else begin : g_sum1
        assign sum_next = SUM_W'(pair_reg[0]);
    end

    assign shifted = sum_next[SUM_W-1:FRAC_BITS];

    always_comb
    begin
        ovf = (shifted[SH_W-1:DATA_W-1] != '0) && (shifted[SH_W-1:DATA_W-1] != '1);
        if (!ovf)
        begin
            result_next = shifted[DATA_W-1:0];
        end
        else if (shifted[SH_W-1])
        begin
            result_next = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            result_next = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_3)
        begin
            result_reg <= result_next;
            clip_reg   <= ovf;
        end
    end

    assign result = result_reg;
    assign clip   = clip_reg;

endmodule

`default_nettype wire

[hw/rtl/vt4_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module vt4_merge #(
    parameter int USED = 4
) (
    input  wire logic           clk,
    input  wire logic           load,
    input  wire vt4_pkg::data_t lane_val [USED],
    input  wire logic [USED-1:0] lane_clip,
    output vt4_pkg::data_t      out_val [vt4_pkg::LANES],
    output logic                sat
);

    import vt4_pkg::*;

    data_t out_reg [LANES];
    logic  sat_reg;

    // rows beyond the matrix size read as zero
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int r = 0; r < LANES; r++)
            begin
                out_reg[r] <= (r < USED) ? lane_val[r] : '0;
            end
            sat_reg <= |lane_clip;
        end
    end

    assign out_val = out_reg;
    assign sat     = sat_reg;

endmodule

`default_nettype wire

[hw/rtl/vector_transform_4x4.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata                                        tuser
// s_axis    in   row_select, elem_a, elem_b, elem_c, elem_d   opcode
// m_axis    out  out_a, out_b, out_c, out_d                   saturated
//
// A transform request passes four registers, the first loaded at the accept
// edge: product, pair add, final add with saturation, output register. One
// request is accepted every cycle unless back-pressure on m_axis fills the
// stages and drops s_axis_tready. A load request writes its row at the accept
// edge and yields no result. Reset clears the matrix and all valid flags. A
// stalled result holds in the output register while earlier stages fill.
module vector_transform_4x4 #(
    parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF,
    parameter int DIM       = vt4_pkg::DIM_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [1:0] row_select, [33:2] elem_a, [65:34] elem_b, [97:66] elem_c,
    // [129:98] elem_d, [135:130] zero
    input  wire logic [135:0] s_axis_tdata,
    // [0] opcode
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] out_a, [63:32] out_b, [95:64] out_c, [127:96] out_d
    output logic [127:0]      m_axis_tdata,
    // [0] saturated
    output logic [0:0]        m_axis_tuser
);

    import vt4_pkg::*;

    localparam int ACTIVE = (DIM < LANES) ? DIM : LANES;

    data_t      elem [LANES];
    data_t      vec [ACTIVE];
    data_t      mat_reg [ACTIVE][ACTIVE];
    data_t      lane_val [ACTIVE];
    logic [ACTIVE-1:0] lane_clip;
    data_t      out_val [LANES];
    logic       sat;
    logic [1:0] row_select;
    logic       opcode;
    logic       in_accept;
    logic       v1_reg, v2_reg, v3_reg, vo_reg;
    logic       v1_next, v2_next, v3_next, vo_next;
    logic       load_o;
    pipe_ctrl_t ctrl;

    assign row_select = s_axis_tdata[1:0];
    assign opcode     = s_axis_tuser[0];

    for (genvar c = 0; c < LANES; c++) begin : g_elem
        assign elem[c] = s_axis_tdata[2 + c*DATA_W +: DATA_W];
    end

    for (genvar c = 0; c < ACTIVE; c++) begin : g_vec
        assign vec[c] = elem[c];
    end

    // pipeline advance: a stage moves when the one after it is empty or moving
    assign load_o        = v3_reg && (!vo_reg || m_axis_tready);
    assign ctrl.load_3   = v2_reg && (!v3_reg || load_o);
    assign ctrl.load_2   = v1_reg && (!v2_reg || ctrl.load_3);
    assign s_axis_tready = !v1_reg || ctrl.load_2;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign ctrl.load_1   = in_accept && (opcode == OP_XFORM);

    assign v1_next = ctrl.load_1 || (v1_reg && !ctrl.load_2);
    assign v2_next = ctrl.load_2 || (v2_reg && !ctrl.load_3);
    assign v3_next = ctrl.load_3 || (v3_reg && !load_o);
    assign vo_next = load_o || (vo_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    // matrix rows; a row index beyond the size drops the load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ACTIVE; r++)
            begin
                for (int c = 0; c < ACTIVE; c++)
                begin
                    mat_reg[r][c] <= '0;
                end
            end
        end
        else if (in_accept && (opcode == OP_LOAD))
        begin
            for (int r = 0; r < ACTIVE; r++)
            begin
                if (row_select == 2'(r))
                begin
                    for (int c = 0; c < ACTIVE; c++)
                    begin
                        mat_reg[r][c] <= elem[c];
                    end
                end
            end
        end
    end

    for (genvar r = 0; r < ACTIVE; r++) begin : g_row
        vt4_lane #(
            .COLS      (ACTIVE),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .ctrl   (ctrl),
            .row    (mat_reg[r]),
            .vec    (vec),
            .result (lane_val[r]),
            .clip   (lane_clip[r])
        );
    end

    vt4_merge #(
        .USED (ACTIVE)
    ) u_merge (
        .clk       (clk),
        .load      (load_o),
        .lane_val  (lane_val),
        .lane_clip (lane_clip),
        .out_val   (out_val),
        .sat       (sat)
    );

    for (genvar r = 0; r < LANES; r++) begin : g_out
        assign m_axis_tdata[r*DATA_W +: DATA_W] = out_val[r];
    end

    assign m_axis_tvalid   = vo_reg;
    assign m_axis_tuser[0] = sat;

    a_xform_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (opcode == OP_XFORM)) |=> v1_reg)
        else $error("accepted transform did not enter the product stage");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(v3_reg))
        else $error("result appeared without a finished stage 3 entry");

    a_matrix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_accept && (opcode == OP_LOAD) && (row_select == 2'd0))
        |=> $stable(mat_reg[0][0]))
        else $error("matrix row 0 changed without a load request");

endmodule

`default_nettype wire
